[rtl/core/ptd_pkg.sv]
`default_nettype none

package ptd_pkg;

  // register widths
  localparam int unsigned SOURCE_W = 8;
  localparam int unsigned PERIOD_W = 40;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 40'd300000000;

  // apb port sizes
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 64;

  // serial divider word width
  localparam int unsigned DIV_W = 64;

  typedef struct packed {
    logic [SOURCE_W-1:0] source_id;
    logic [PERIOD_W-1:0] period_us;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] numer;
    logic [DIV_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/core/ptd_cfg_regs.sv]
`default_nettype none

module ptd_cfg_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ptd_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [ptd_pkg::APB_DATA_W-1:0]      pwdata,
  output logic      [ptd_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                     pready,
  output ptd_pkg::cfg_t                            cfg_o
);

  // register index, taken from the 8-byte slot of the address
  localparam logic RegSourceId = 1'b0;
  localparam logic RegPeriod   = 1'b1;

  logic                          reg_sel;
  logic                          wr_en;
  logic [ptd_pkg::SOURCE_W-1:0]  source_id_q;
  logic [ptd_pkg::PERIOD_W-1:0]  period_q;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_id_q <= '0;
      period_q    <= ptd_pkg::PERIOD_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegSourceId: source_id_q <= pwdata[ptd_pkg::SOURCE_W-1:0];
        RegPeriod:   period_q    <= pwdata[ptd_pkg::PERIOD_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      RegSourceId: prdata[ptd_pkg::SOURCE_W-1:0] = source_id_q;
      RegPeriod:   prdata[ptd_pkg::PERIOD_W-1:0] = period_q;
      default:     ;
    endcase
  end

  assign cfg_o.source_id = source_id_q;
  assign cfg_o.period_us = period_q;

endmodule

`default_nettype wire

[rtl/core/ptd_serial_div.sv]
`default_nettype none

// restoring divider, one quotient bit per cycle
module ptd_serial_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ptd_pkg::div_req_t req_i,
  output ptd_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned W    = ptd_pkg::DIV_W;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    num_q;
  logic [W-1:0]    rem_q;
  logic [W-1:0]    den_q;
  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [W:0]      trial;
  logic [W:0]      diff;
  logic            fits;

  always_comb begin
    trial = {rem_q, num_q[W-1]};
    diff  = trial - {1'b0, den_q};
    fits  = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= CntW'(W);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CntW'(1));
      end
    end
  end

  // quotient bits shift in behind the numerator
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.numer;
      rem_q <= '0;
      den_q <= req_i.denom;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[W-2:0], fits};
      rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

[rtl/core/pps_time_discipline.sv]
`default_nettype none

// PPS time discipline. A PPS word (tuser command 0) captures the local microsecond
// time and arms the block; a timestamp word (command 1) from the configured sender,
// arriving while armed, adds remote_sec*1e6 minus the captured time to a running
// offset sum, counts one sample (saturating at 65535), steps the clock to the
// remote time when the whole seconds differ by more than 3600, and, once more than
// two samples are in, more than half a period has passed since the last adjust
// and the time lies in the first 3 percent of a period, emits now plus the
// truncated mean offset and clears sum and count. Every input word gives exactly
// one result word. The single shared 64-bit restoring divider makes one quotient
// bit per cycle and serves the seconds of the captured time, the time modulo the
// period and the mean offset in turn. A new word is taken when the sequencer is
// idle, even while the previous result waits in the output register. Configuration
// is an APB port: source_id at byte address 0, period_us at byte address 8.
module pps_time_discipline (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // slave side
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // local_time_us[62:0], sender_id[70:63], remote_sec[102:71],
  // remote_usec[122:103], zero fill
  input  wire logic [127:0]                   s_axis_tdata,
  // command[0]
  input  wire logic [0:0]                     s_axis_tuser,
  // master side
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // step_time_us[62:0], adjust_time_us[125:63], zero fill
  output logic [127:0]                        m_axis_tdata,
  // status[1:0], step_valid[2], adjust_valid[3]
  output logic [3:0]                          m_axis_tuser,
  // configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ptd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [ptd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [ptd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);

  localparam int unsigned TimeW   = 63;
  localparam int unsigned SumW    = 64;
  localparam int unsigned CountW  = 16;
  localparam int unsigned SecW    = 32;
  localparam int unsigned UsecW   = 20;
  localparam int unsigned ProdW   = SecW + UsecW;
  localparam int unsigned CapSecW = 44;   // seconds of a 63-bit microsecond time
  localparam int unsigned PW      = ptd_pkg::PERIOD_W;
  localparam int unsigned WinW    = 48;

  localparam logic [UsecW-1:0]   UsecPerSec   = 20'd1000000;
  localparam logic [CapSecW-1:0] StepLimitSec = 44'd3600;
  localparam logic [CountW-1:0]  MinSamples   = 16'd2;
  localparam logic [WinW-1:0]    WindowDen    = 48'd100;

  localparam logic CmdPps = 1'b0;

  localparam logic [1:0] StatPps         = 2'd0;
  localparam logic [1:0] StatWrongSender = 2'd1;
  localparam logic [1:0] StatNoPps       = 2'd2;
  localparam logic [1:0] StatSample      = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PPS_DIV,
    ST_MUL,
    ST_EVAL,
    ST_QUAL,
    ST_MOD_DIV,
    ST_AVG_DIV,
    ST_FINISH
  } state_e;

  ptd_pkg::cfg_t     cfg;
  ptd_pkg::div_req_t div_req;
  ptd_pkg::div_rsp_t div_rsp;

  state_e state_q;

  // latched input word
  logic                         cmd_q;
  logic [TimeW-1:0]             local_q;
  logic [ptd_pkg::SOURCE_W-1:0] sender_q;
  logic [SecW-1:0]              rsec_q;
  logic [UsecW-1:0]             rusec_q;

  // discipline state
  logic                         armed_q;
  logic [TimeW-1:0]             cap_q;
  logic [CapSecW-1:0]           cap_sec_q;
  logic [SumW-1:0]              sum_q;
  logic [CountW-1:0]            cnt_q;
  logic [TimeW-1:0]             last_q;

  // per-item work registers
  logic [ProdW-1:0]             prod_q;
  logic                         step_q;
  logic [TimeW-1:0]             now_q;
  logic [PW+1:0]                lim3_q;
  logic                         neg_q;

  // pending result
  logic [1:0]                   res_status_q;
  logic                         res_step_v_q;
  logic [TimeW-1:0]             res_step_t_q;
  logic                         res_adj_v_q;
  logic [TimeW-1:0]             res_adj_t_q;

  // output register
  logic                         out_valid_q;
  logic [1:0]                   out_status_q;
  logic                         out_step_v_q;
  logic [TimeW-1:0]             out_step_t_q;
  logic                         out_adj_v_q;
  logic [TimeW-1:0]             out_adj_t_q;

  // combinational helpers
  logic [CapSecW-1:0]           rsec_ext;
  logic [CapSecW-1:0]           dsec;
  logic [TimeW-1:0]             step_t;
  logic [SumW-1:0]              sum_d;
  logic [CountW-1:0]            cnt_d;
  logic [TimeW-1:0]             elapsed;
  logic                         qualify;
  logic [PW:0]                  rem_inc;
  logic [WinW-1:0]              win_lhs;
  logic                         win_ok;
  logic [SumW-1:0]              sum_mag;
  logic [TimeW-1:0]             adj_t;

  ptd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ptd_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    // distance in whole seconds between remote and captured time
    rsec_ext = CapSecW'(rsec_q);
    dsec     = (rsec_ext >= cap_sec_q) ? (rsec_ext - cap_sec_q) : (cap_sec_q - rsec_ext);

    step_t = TimeW'(prod_q) + TimeW'(rusec_q);
    sum_d  = sum_q + SumW'(prod_q) - SumW'(cap_q);
    cnt_d  = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

    // half-period test on the already updated count
    elapsed = now_q - last_q;
    qualify = (cnt_q > MinSamples) && (cfg.period_us != '0) && (now_q > last_q) &&
              (elapsed > TimeW'(cfg.period_us >> 1));

    // r < floor(3p/100) is the same as 100*(r+1) <= 3p
    rem_inc = {1'b0, div_rsp.rem[PW-1:0]} + 1'b1;
    win_lhs = WinW'(rem_inc) * WindowDen;
    win_ok  = win_lhs <= WinW'(lim3_q);

    sum_mag = sum_q[SumW-1] ? (~sum_q + 1'b1) : sum_q;
    adj_t   = neg_q ? (now_q - div_rsp.quot[TimeW-1:0]) : (now_q + div_rsp.quot[TimeW-1:0]);
  end

  // divider requests
  always_comb begin
    div_req = '0;
    unique case (state_q)
      ST_DECODE: begin
        if (cmd_q == CmdPps) begin
          div_req.start = 1'b1;
          div_req.numer = ptd_pkg::DIV_W'(local_q);
          div_req.denom = ptd_pkg::DIV_W'(UsecPerSec);
        end
      end
      ST_QUAL: begin
        if (qualify) begin
          div_req.start = 1'b1;
          div_req.numer = ptd_pkg::DIV_W'(now_q);
          div_req.denom = ptd_pkg::DIV_W'(cfg.period_us);
        end
      end
      ST_MOD_DIV: begin
        if (div_rsp.done && win_ok) begin
          div_req.start = 1'b1;
          div_req.numer = sum_mag;
          div_req.denom = ptd_pkg::DIV_W'(cnt_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cmd_q        <= 1'b0;
      local_q      <= '0;
      sender_q     <= '0;
      rsec_q       <= '0;
      rusec_q      <= '0;
      armed_q      <= 1'b0;
      cap_q        <= '0;
      cap_sec_q    <= '0;
      sum_q        <= '0;
      cnt_q        <= '0;
      last_q       <= '0;
      prod_q       <= '0;
      step_q       <= 1'b0;
      now_q        <= '0;
      lim3_q       <= '0;
      neg_q        <= 1'b0;
      res_status_q <= StatPps;
      res_step_v_q <= 1'b0;
      res_step_t_q <= '0;
      res_adj_v_q  <= 1'b0;
      res_adj_t_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= StatPps;
      out_step_v_q <= 1'b0;
      out_step_t_q <= '0;
      out_adj_v_q  <= 1'b0;
      out_adj_t_q  <= '0;
    end else begin
      // in the finish state the output register is either reloaded or held
      if (m_axis_tready && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q    <= s_axis_tuser[0];
            local_q  <= s_axis_tdata[62:0];
            sender_q <= s_axis_tdata[70:63];
            rsec_q   <= s_axis_tdata[102:71];
            rusec_q  <= s_axis_tdata[122:103];
            state_q  <= ST_DECODE;
          end
        end

        ST_DECODE: begin
          res_step_v_q <= 1'b0;
          res_step_t_q <= '0;
          res_adj_v_q  <= 1'b0;
          res_adj_t_q  <= '0;
          if (cmd_q == CmdPps) begin
            cap_q        <= local_q;
            armed_q      <= 1'b1;
            res_status_q <= StatPps;
            state_q      <= ST_PPS_DIV;
          end else if (sender_q != cfg.source_id) begin
            res_status_q <= StatWrongSender;
            state_q      <= ST_FINISH;
          end else if (!armed_q) begin
            res_status_q <= StatNoPps;
            state_q      <= ST_FINISH;
          end else begin
            res_status_q <= StatSample;
            state_q      <= ST_MUL;
          end
        end

        // captured seconds come out of the divider
        ST_PPS_DIV: begin
          if (div_rsp.done) begin
            cap_sec_q <= div_rsp.quot[CapSecW-1:0];
            state_q   <= ST_FINISH;
          end
        end

        ST_MUL: begin
          prod_q  <= rsec_q * UsecPerSec;
          step_q  <= dsec > StepLimitSec;
          state_q <= ST_EVAL;
        end

        ST_EVAL: begin
          now_q        <= step_q ? step_t : local_q;
          res_step_v_q <= step_q;
          res_step_t_q <= step_q ? step_t : '0;
          sum_q        <= sum_d;
          cnt_q        <= cnt_d;
          armed_q      <= 1'b0;
          state_q      <= ST_QUAL;
        end

        ST_QUAL: begin
          lim3_q  <= {2'b00, cfg.period_us} + {1'b0, cfg.period_us, 1'b0};
          state_q <= qualify ? ST_MOD_DIV : ST_FINISH;
        end

        ST_MOD_DIV: begin
          if (div_rsp.done) begin
            neg_q   <= sum_q[SumW-1];
            state_q <= win_ok ? ST_AVG_DIV : ST_FINISH;
          end
        end

        // averaged correction taken: restart the average
        ST_AVG_DIV: begin
          if (div_rsp.done) begin
            res_adj_v_q <= 1'b1;
            res_adj_t_q <= adj_t;
            last_q      <= now_q;
            sum_q       <= '0;
            cnt_q       <= '0;
            state_q     <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_step_v_q <= res_step_v_q;
            out_step_t_q <= res_step_t_q;
            out_adj_v_q  <= res_adj_v_q;
            out_adj_t_q  <= res_adj_t_q;
            state_q      <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = {out_adj_v_q, out_step_v_q, out_status_q};
  assign m_axis_tdata  = {2'b00, out_adj_t_q, out_step_t_q};

  // one word in flight through the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a word is still in progress");

  // an adjust only ever rides on a used sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tuser[1:0] == StatSample)
    else $error("adjust flagged on a result that used no sample");

  // divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_PPS_DIV) || (state_q == ST_MOD_DIV) ||
                     (state_q == ST_AVG_DIV))
    else $error("divider result arrived outside a divide state");

  // a used sample disarms the pps capture
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EVAL |=> !armed_q && (state_q == ST_QUAL))
    else $error("pps still armed after a sample was used");

endmodule

`default_nettype wire
